@@ rtl/core/hcb_pkg.sv @@
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared field widths and the result record of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int SYM_W     = 8;
  localparam int IN_FREQ_W = 24;
  localparam int CODE_W    = 15;
  localparam int LEN_W     = 4;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic              dropped;
  } hcb_result_t;

endpackage

@@ rtl/core/huffman_code_builder.sv @@
// After the last pair has been loaded the build runs a sort, a merge and a
// walk of the tree, plus the output transaction for each code. One set is
// handled at a time; sort and merge read the working order through the
// single read port of its memory. No input taken while building or
// emitting. Reset (rst_n low) empties the store and idles the output.
// ----------------------------------------------------------------------------
// huffman_code_builder
// Collects symbol/frequency pairs, builds a Huffman tree in memories and
// emits one code per symbol in preorder leaf order.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 16,
  parameter int FREQ_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] symbol, [31:8] frequency
  input  logic        in_tlast,   // last_symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] coded_symbol, [22:8] code_bits,
                                  // [26:23] code_length, zero pad above
  output logic        out_tlast,  // last_code
  output logic        out_tuser   // dropped_symbols
);
  import hcb_pkg::*;

  localparam int IW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int NW = $clog2(2 * MAX_SYMBOLS - 1);
  localparam int NF = FREQ_BITS + IW;
  localparam int OW = NW + NF;
  localparam int SW = NW + CODE_W + LEN_W;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SINIT, ST_SLEAF, ST_INS, ST_CMP, ST_MCHK, ST_ML, ST_MR,
    ST_ROOT, ST_WCUR, ST_WCH, ST_WSYM, ST_WOUT, ST_WPOP
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r, i_r, k_r, sp_r;
  logic              ovf_r, merge_r;
  logic [IW-1:0]     j_r;
  logic [NW-1:0]     next_r, idx_r, cur_node_r;
  logic [NF-1:0]     v_r;
  logic [OW-1:0]     left_r;
  logic [CODE_W-1:0] cur_code_r;
  logic [LEN_W-1:0]  cur_len_r;

  // memory ports
  logic                 sym_we;
  logic [SYM_W-1:0]     sym_rdata;
  logic [FREQ_BITS-1:0] frq_rdata;
  logic                 ord_we;
  logic [IW-1:0]        ord_raddr;
  logic [OW-1:0]        ord_wdata, ord_rdata;
  logic                 chd_we;
  logic [2*NW-1:0]      chd_rdata;
  logic                 stk_we;
  logic [SW-1:0]        stk_wdata, stk_rdata;

  logic          in_acc, store_room, ord_less, out_ld, out_done;
  logic [NW-1:0] count_n, slot_w, slot_r;
  logic [CW-1:0] sp_m1, k_m1, k_m2;
  hcb_result_t   res;

  assign in_tready  = (state_r == ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign store_room = (count_r != CW'(MAX_SYMBOLS));
  assign sym_we     = in_acc && store_room;
  assign count_n    = NW'(count_r);
  assign slot_w     = next_r - count_n;
  assign slot_r     = cur_node_r - count_n;
  assign sp_m1      = sp_r - 1'b1;
  assign k_m1       = k_r - 1'b1;
  assign k_m2       = k_r - CW'(2);
  assign ord_less   = (ord_rdata[NF-1:0] < v_r);

  always_comb begin
    ord_we    = 1'b0;
    ord_wdata = {idx_r, v_r};
    ord_raddr = '0;
    unique case (state_r)
      ST_INS: begin
        ord_we    = (j_r == '0);
        ord_raddr = j_r - 1'b1;
      end
      ST_CMP: begin
        ord_we = 1'b1;
        if (ord_less) begin
          ord_wdata = ord_rdata;
        end
      end
      ST_MCHK: ord_raddr = (k_r <= CW'(1)) ? '0 : k_m2[IW-1:0];
      ST_ML:   ord_raddr = k_m1[IW-1:0];
      default: ord_raddr = '0;
    endcase
  end

  assign chd_we    = (state_r == ST_MR);
  assign stk_we    = (state_r == ST_WCH);
  assign stk_wdata = {chd_rdata[NW-1:0], cur_code_r[CODE_W-2:0], 1'b1,
                      cur_len_r + 1'b1};
  assign out_ld    = (state_r == ST_WSYM);

  hcb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_sym (
    .clk(clk), .we(sym_we), .waddr(count_r[IW-1:0]), .wdata(in_tdata[7:0]),
    .raddr(cur_node_r[IW-1:0]), .rdata(sym_rdata)
  );

  hcb_ram #(.WIDTH(FREQ_BITS), .DEPTH(MAX_SYMBOLS)) u_freq (
    .clk(clk), .we(sym_we), .waddr(count_r[IW-1:0]),
    .wdata(FREQ_BITS'(in_tdata[31:8])),
    .raddr(i_r[IW-1:0]), .rdata(frq_rdata)
  );

  // working order: node index and its frequency side by side
  hcb_ram #(.WIDTH(OW), .DEPTH(MAX_SYMBOLS)) u_order (
    .clk(clk), .we(ord_we), .waddr(j_r), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  hcb_ram #(.WIDTH(2*NW), .DEPTH(MAX_SYMBOLS)) u_child (
    .clk(clk), .we(chd_we), .waddr(slot_w[IW-1:0]),
    .wdata({left_r[OW-1:NF], ord_rdata[OW-1:NF]}),
    .raddr(slot_r[IW-1:0]), .rdata(chd_rdata)
  );

  // pending right subtrees of the walk
  hcb_ram #(.WIDTH(SW), .DEPTH(MAX_SYMBOLS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp_r[IW-1:0]), .wdata(stk_wdata),
    .raddr(sp_m1[IW-1:0]), .rdata(stk_rdata)
  );

  always_comb begin
    res.sym     = sym_rdata;
    res.code    = cur_code_r;
    res.len     = cur_len_r;
    res.last    = (sp_r == '0);
    res.dropped = ovf_r;
  end

  hcb_out_stage u_out (
    .clk(clk), .rst_n(rst_n), .ld(out_ld), .res(res), .out_tready(out_tready),
    .out_tvalid(out_tvalid), .out_tdata(out_tdata), .out_tlast(out_tlast),
    .out_tuser(out_tuser), .done(out_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      merge_r <= 1'b0;
      i_r     <= '0;
      k_r     <= '0;
      sp_r    <= '0;
      j_r     <= '0;
      next_r  <= '0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_room) begin
              count_r <= count_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast) begin
              i_r     <= '0;
              merge_r <= 1'b0;
              state_r <= ST_SINIT;
            end
          end
        end
        ST_SINIT: begin
          if (i_r == count_r) begin
            k_r     <= count_r;
            next_r  <= count_n;
            merge_r <= 1'b1;
            state_r <= ST_MCHK;
          end else begin
            state_r <= ST_SLEAF;
          end
        end
        ST_SLEAF: begin
          v_r     <= NF'(frq_rdata);
          idx_r   <= NW'(i_r);
          j_r     <= i_r[IW-1:0];
          state_r <= ST_INS;
        end
        ST_INS, ST_CMP: begin
          if (state_r == ST_INS && j_r != '0) begin
            state_r <= ST_CMP;
          end else if (state_r == ST_CMP && ord_less) begin
            j_r     <= j_r - 1'b1;
            state_r <= ST_INS;
          end else if (merge_r) begin
            next_r  <= next_r + 1'b1;
            state_r <= ST_MCHK;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= ST_SINIT;
          end
        end
        ST_MCHK: state_r <= (k_r <= CW'(1)) ? ST_ROOT : ST_ML;
        ST_ML: begin
          left_r  <= ord_rdata;
          state_r <= ST_MR;
        end
        ST_MR: begin
          v_r     <= left_r[NF-1:0] + ord_rdata[NF-1:0];
          idx_r   <= next_r;
          k_r     <= k_m1;
          j_r     <= k_m2[IW-1:0];
          state_r <= ST_INS;
        end
        ST_ROOT: begin
          cur_node_r <= ord_rdata[OW-1:NF];
          cur_code_r <= '0;
          cur_len_r  <= '0;
          sp_r       <= '0;
          state_r    <= ST_WCUR;
        end
        ST_WCUR: state_r <= (cur_node_r < count_n) ? ST_WSYM : ST_WCH;
        ST_WCH: begin
          sp_r       <= sp_r + 1'b1;
          cur_node_r <= chd_rdata[2*NW-1:NW];
          cur_code_r <= {cur_code_r[CODE_W-2:0], 1'b0};
          cur_len_r  <= cur_len_r + 1'b1;
          state_r    <= ST_WCUR;
        end
        ST_WSYM: state_r <= ST_WOUT;
        ST_WOUT: begin
          if (out_done) begin
            if (sp_r == '0) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              sp_r    <= sp_m1;
              state_r <= ST_WPOP;
            end
          end
        end
        ST_WPOP: begin
          cur_node_r <= stk_rdata[SW-1:CODE_W+LEN_W];
          cur_code_r <= stk_rdata[CODE_W+LEN_W-1:LEN_W];
          cur_len_r  <= stk_rdata[LEN_W-1:0];
          state_r    <= ST_WCUR;
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SYMBOLS))
    else $error("symbol count beyond capacity");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r < CW'(MAX_SYMBOLS))
    else $error("walk stack overflow");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (count_r == '0 && !ovf_r))
    else $error("store not cleared after final code");

endmodule

@@ rtl/core/hcb_ram.sv @@
// ----------------------------------------------------------------------------
// hcb_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/hcb_out_stage.sv @@
// ----------------------------------------------------------------------------
// hcb_out_stage
// Output register for code results; holds a result until the sink takes it.
// ----------------------------------------------------------------------------
module hcb_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld,
  input  hcb_pkg::hcb_result_t res,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [31:0]         out_tdata,
  output logic                out_tlast,
  output logic                out_tuser,
  output logic                done
);
  import hcb_pkg::*;

  hcb_result_t res_r;
  logic        valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= 1'b1;
    end else if (valid_r && out_tready) begin
      valid_r <= 1'b0;
    end
    if (ld) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, res_r.len, res_r.code, res_r.sym};
  assign out_tlast  = res_r.last;
  assign out_tuser  = res_r.dropped;
  assign done       = valid_r && out_tready;

endmodule
